// ===== hw/rtl/calendar_clock_with_alarm_core_assert.svh =====
// Assertion macros shared by the calendar clock RTL.
`ifndef CALENDAR_CLOCK_WITH_ALARM_CORE_ASSERT_SVH
`define CALENDAR_CLOCK_WITH_ALARM_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define CCAL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define CCAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ccal_pkg.sv =====
// Shared types, operation codes and calendar helpers for the calendar clock.
`timescale 1ns / 1ps

package ccal_pkg;

    // Operation codes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_ALARM  = 3'd2;
    localparam logic [2:0] OP_DISARM = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;

    // Limits
    localparam logic [6:0] MAX_CENT = 7'd99;
    localparam logic [6:0] MAX_YEAR = 7'd99;
    localparam logic [3:0] MAX_MON  = 4'd12;
    localparam logic [4:0] MAX_HOUR = 5'd23;
    localparam logic [5:0] MAX_MIN  = 6'd59;
    localparam logic [5:0] MAX_SEC  = 6'd59;
    localparam logic [2:0] MAX_WDAY = 3'd7;

    // Date and time, most significant field first; packing matches the alarm compare order
    typedef struct packed {
        logic [6:0] cent;
        logic [6:0] year;
        logic [3:0] mon;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] min;
        logic [5:0] sec;
    } t_time;

    // Time plus weekday, as handed between the update units and the top
    typedef struct packed {
        t_time      tm;
        logic [2:0] wday;
    } t_stamp;

    // Days in a month; leap years on the full year, a year 00 uses the century
    function automatic logic [4:0] days_in_month(input logic [6:0] cent,
                                                 input logic [6:0] year,
                                                 input logic [3:0] mon);
        logic leap;
        logic [4:0] days;
        leap = (year == 7'd0) ? (cent[1:0] == 2'd0) : (year[1:0] == 2'd0);
        case (mon)
            4'd2:    days = leap ? 5'd29 : 5'd28;
            4'd4:    days = 5'd30;
            4'd6:    days = 5'd30;
            4'd9:    days = 5'd30;
            4'd11:   days = 5'd30;
            default: days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

// ===== hw/rtl/ccal_load.sv =====
// Clamps the date, time and weekday fields of a load command into range.
`timescale 1ns / 1ps

module ccal_load import ccal_pkg::*; (
    input  t_time      i_raw_tm,
    input  logic [2:0] i_raw_wday,
    output t_stamp     o_stamp
);

    logic [4:0] w_dim;

    // Field clamps; day depends on the clamped month and year
    always_comb begin
        o_stamp.tm.cent = (i_raw_tm.cent > MAX_CENT) ? MAX_CENT : i_raw_tm.cent;
        o_stamp.tm.year = (i_raw_tm.year > MAX_YEAR) ? MAX_YEAR : i_raw_tm.year;
        if (i_raw_tm.mon == 4'd0) begin
            o_stamp.tm.mon = 4'd1;
        end else if (i_raw_tm.mon > MAX_MON) begin
            o_stamp.tm.mon = MAX_MON;
        end else begin
            o_stamp.tm.mon = i_raw_tm.mon;
        end
        w_dim = days_in_month(o_stamp.tm.cent, o_stamp.tm.year, o_stamp.tm.mon);
        if (i_raw_tm.day == 5'd0) begin
            o_stamp.tm.day = 5'd1;
        end else if (i_raw_tm.day > w_dim) begin
            o_stamp.tm.day = w_dim;
        end else begin
            o_stamp.tm.day = i_raw_tm.day;
        end
        o_stamp.tm.hour = (i_raw_tm.hour > MAX_HOUR) ? MAX_HOUR : i_raw_tm.hour;
        o_stamp.tm.min  = (i_raw_tm.min  > MAX_MIN)  ? MAX_MIN  : i_raw_tm.min;
        o_stamp.tm.sec  = (i_raw_tm.sec  > MAX_SEC)  ? MAX_SEC  : i_raw_tm.sec;
        o_stamp.wday    = (i_raw_wday == 3'd0) ? 3'd1 : i_raw_wday;
    end

endmodule

// ===== hw/rtl/ccal_adv.sv =====
// One-second advance of the clock with the full carry chain, plus the alarm compare.
`timescale 1ns / 1ps

module ccal_adv import ccal_pkg::*; (
    input  t_stamp i_now,
    input  t_time  i_alarm,
    output t_stamp o_next,
    output logic   o_alarm_hit
);

    logic       w_sec_c;
    logic       w_min_c;
    logic       w_hour_c;
    logic       w_day_c;
    logic       w_mon_c;
    logic       w_year_c;
    logic [4:0] w_dim;

    // Carry chain: each field wraps only when all lower fields wrap
    always_comb begin
        w_dim    = days_in_month(i_now.tm.cent, i_now.tm.year, i_now.tm.mon);
        w_sec_c  = (i_now.tm.sec  >= MAX_SEC);
        w_min_c  = w_sec_c  && (i_now.tm.min  >= MAX_MIN);
        w_hour_c = w_min_c  && (i_now.tm.hour >= MAX_HOUR);
        w_day_c  = w_hour_c && (i_now.tm.day  >= w_dim);
        w_mon_c  = w_day_c  && (i_now.tm.mon  >= MAX_MON);
        w_year_c = w_mon_c  && (i_now.tm.year >= MAX_YEAR);

        o_next = i_now;
        o_next.tm.sec = w_sec_c ? 6'd0 : i_now.tm.sec + 6'd1;
        if (w_sec_c) begin
            o_next.tm.min = w_min_c ? 6'd0 : i_now.tm.min + 6'd1;
        end
        if (w_min_c) begin
            o_next.tm.hour = w_hour_c ? 5'd0 : i_now.tm.hour + 5'd1;
        end
        if (w_hour_c) begin
            o_next.wday   = (i_now.wday >= MAX_WDAY) ? 3'd1 : i_now.wday + 3'd1;
            o_next.tm.day = w_day_c ? 5'd1 : i_now.tm.day + 5'd1;
        end
        if (w_day_c) begin
            o_next.tm.mon = w_mon_c ? 4'd1 : i_now.tm.mon + 4'd1;
        end
        if (w_mon_c) begin
            o_next.tm.year = w_year_c ? 7'd0 : i_now.tm.year + 7'd1;
        end
        if (w_year_c) begin
            o_next.tm.cent = (i_now.tm.cent >= MAX_CENT) ? 7'd0 : i_now.tm.cent + 7'd1;
        end
    end

    // Alarm is due once the advanced time reaches or passes it
    assign o_alarm_hit = (o_next.tm >= i_alarm);

endmodule

// ===== hw/rtl/calendar_clock_with_alarm_core.sv =====
// Real-time clock calendar with one-shot alarm: a tick or a command goes in per beat, and
// every beat returns one result with the time, weekday and flags as they stand after it.
// Throughput is one beat per clock while the result side does not stall; an accepted beat is
// held in the input register, and the clock state and result register update together when it
// moves on, so each result passes through the input register and then the result register.
// The carry chain through all calendar fields and the 40-bit alarm compare, both evaluated
// combinationally, set the critical path. Back-pressure on the result side stalls the input
// register and, through it, the input ready.
`timescale 1ns / 1ps

module calendar_clock_with_alarm_core import ccal_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_operation,
    input  logic [6:0] i_century,
    input  logic [6:0] i_year_in_century,
    input  logic [3:0] i_month,
    input  logic [4:0] i_day,
    input  logic [4:0] i_hour,
    input  logic [5:0] i_minute,
    input  logic [5:0] i_second,
    input  logic [2:0] i_weekday,
    // Result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [6:0] o_now_century,
    output logic [6:0] o_now_year,
    output logic [3:0] o_now_month,
    output logic [4:0] o_now_day,
    output logic [4:0] o_now_hour,
    output logic [5:0] o_now_minute,
    output logic [5:0] o_now_second,
    output logic [2:0] o_now_weekday,
    output logic       o_alarm_fired,
    output logic       o_alarm_armed,
    output logic       o_running
);

    // Input register
    logic       r_in_vld;
    logic [2:0] r_op;
    t_time      r_raw_tm;
    logic [2:0] r_raw_wday;

    // Clock state
    t_stamp     r_now;
    t_stamp     n_now;
    t_time      r_alarm;
    t_time      n_alarm;
    logic       r_armed;
    logic       n_armed;
    logic       r_run;
    logic       n_run;
    logic       n_fired;

    // Result register
    logic       r_out_vld;
    t_stamp     r_o_now;
    logic       r_o_fired;
    logic       r_o_armed;
    logic       r_o_run;

    logic       w_adv;
    t_stamp     w_ld;
    t_stamp     w_tick;
    logic       w_hit;

    // Pipeline flow: the input stage moves when the result register is free or draining
    assign w_adv   = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_op       <= i_operation;
            r_raw_tm   <= '{cent: i_century, year: i_year_in_century, mon: i_month,
                            day: i_day, hour: i_hour, min: i_minute, sec: i_second};
            r_raw_wday <= i_weekday;
        end
    end

    ccal_load u_load (
        .i_raw_tm   (r_raw_tm),
        .i_raw_wday (r_raw_wday),
        .o_stamp    (w_ld)
    );

    ccal_adv u_adv (
        .i_now       (r_now),
        .i_alarm     (r_alarm),
        .o_next      (w_tick),
        .o_alarm_hit (w_hit)
    );

    // Command decode and next state
    always_comb begin
        n_now   = r_now;
        n_alarm = r_alarm;
        n_armed = r_armed;
        n_run   = r_run;
        n_fired = 1'b0;
        case (r_op)
            OP_TICK: begin
                if (r_run) begin
                    n_now = w_tick;
                    if (r_armed && w_hit) begin
                        n_fired = 1'b1;
                        n_armed = 1'b0;
                    end
                end
            end
            OP_LOAD: begin
                n_now = w_ld;
                n_run = 1'b1;
            end
            OP_ALARM: begin
                n_alarm = w_ld.tm;
                n_armed = 1'b1;
            end
            OP_DISARM: begin
                n_armed = 1'b0;
            end
            OP_STOP: begin
                n_run = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Clock state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now   <= '{tm: '{cent: 7'd20, year: 7'd0, mon: 4'd1, day: 5'd1,
                               hour: 5'd0, min: 6'd0, sec: 6'd0},
                         wday: 3'd1};
            r_alarm <= '0;
            r_armed <= 1'b0;
            r_run   <= 1'b0;
        end else if (w_adv) begin
            r_now   <= n_now;
            r_alarm <= n_alarm;
            r_armed <= n_armed;
            r_run   <= n_run;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
        if (w_adv) begin
            r_o_now   <= n_now;
            r_o_fired <= n_fired;
            r_o_armed <= n_armed;
            r_o_run   <= n_run;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_now_century = r_o_now.tm.cent;
    assign o_now_year    = r_o_now.tm.year;
    assign o_now_month   = r_o_now.tm.mon;
    assign o_now_day     = r_o_now.tm.day;
    assign o_now_hour    = r_o_now.tm.hour;
    assign o_now_minute  = r_o_now.tm.min;
    assign o_now_second  = r_o_now.tm.sec;
    assign o_now_weekday = r_o_now.wday;
    assign o_alarm_fired = r_o_fired;
    assign o_alarm_armed = r_o_armed;
    assign o_running     = r_o_run;

`include "calendar_clock_with_alarm_core_assert.svh"

    // A fired alarm is always reported disarmed
    `CCAL_ASSERT_NOW(a_fire_disarms, i_clk, i_rst_n, o_valid && o_alarm_fired, !o_alarm_armed, "alarm fired but still armed")
    // Firing needs a running clock, an armed alarm and a tick
    `CCAL_ASSERT_NOW(a_fire_cause, i_clk, i_rst_n, w_adv && n_fired, (r_op == OP_TICK) && r_run && r_armed, "alarm fired without an armed tick")
    // Clock state only moves when a beat is processed
    `CCAL_ASSERT_NEXT(a_state_hold, i_clk, i_rst_n, !w_adv, $stable(r_now) && $stable(r_armed) && $stable(r_run), "clock state changed with no beat")

endmodule

// ===== tb/sv/calendar_clock_with_alarm_core_test.sv =====
// Self-checking testbench for the calendar clock core: directed and random beats against a predictor.
`timescale 1ns / 1ps

module calendar_clock_with_alarm_core_test import ccal_pkg::*; ();

    localparam int RANDOM_ITEMS  = 1700;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int NUM_OP_CODES  = 8;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 8;
    localparam int MAX_PRINTED   = 100;

    // One command beat, fields at port widths
    typedef struct packed {
        logic [2:0] op;
        logic [6:0] cen;
        logic [6:0] yr;
        logic [3:0] mon;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] min;
        logic [5:0] sec;
        logic [2:0] wday;
    } t_cmd;

    // One result beat
    typedef struct packed {
        t_stamp stamp;
        logic   fired;
        logic   armed;
        logic   running;
    } t_reading;

    // Calendar predictor plus the queue of readings still owed by the core
    class t_clock_scoreboard;
        t_stamp   clock_now;
        t_time    alarm_at;
        bit       alarm_pending;
        bit       clock_running;
        t_reading expected_readings[$];
        int       errors;
        int       readings_seen;

        function new();
            clock_now     = '0;
            clock_now.tm.cent = 7'd20;
            clock_now.tm.mon  = 4'd1;
            clock_now.tm.day  = 5'd1;
            clock_now.wday    = 3'd1;
            alarm_at      = '0;
            alarm_pending = 1'b0;
            clock_running = 1'b0;
            errors        = 0;
            readings_seen = 0;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        function int unsigned bound(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        // Gregorian length; year 00 takes its leap status from the century
        function int unsigned month_length(int unsigned cen, int unsigned yr,
                                           int unsigned mon);
            bit leap_year;
            leap_year = (yr == 0) ? (cen % 4 == 0) : (yr % 4 == 0);
            if (mon == 2) return leap_year ? 29 : 28;
            if (mon == 4 || mon == 6 || mon == 9 || mon == 11) return 30;
            return 31;
        endfunction

        // One second forward with the full carry chain
        function t_stamp step_second(t_stamp s);
            t_stamp n;
            n = s;
            n.tm.sec = n.tm.sec + 6'd1;
            if (n.tm.sec < 60) return n;
            n.tm.sec = '0;
            n.tm.min = n.tm.min + 6'd1;
            if (n.tm.min < 60) return n;
            n.tm.min = '0;
            n.tm.hour = n.tm.hour + 5'd1;
            if (n.tm.hour < 24) return n;
            n.tm.hour = '0;
            n.wday = (n.wday >= 3'd7) ? 3'd1 : n.wday + 3'd1;
            if (n.tm.day < month_length(n.tm.cent, n.tm.year, n.tm.mon)) begin
                n.tm.day = n.tm.day + 5'd1;
                return n;
            end
            n.tm.day = 5'd1;
            n.tm.mon = n.tm.mon + 4'd1;
            if (n.tm.mon <= 12) return n;
            n.tm.mon = 4'd1;
            n.tm.year = n.tm.year + 7'd1;
            if (n.tm.year <= 99) return n;
            n.tm.year = '0;
            n.tm.cent = (n.tm.cent >= 7'd99) ? 7'd0 : n.tm.cent + 7'd1;
            return n;
        endfunction

        // Apply an accepted command and queue the reading it produces
        function void accept_command(t_cmd c);
            int unsigned cen, yr, mon;
            t_time    loaded;
            t_reading r;
            bit       fired;
            cen = bound(c.cen, 0, 99);
            yr  = bound(c.yr, 0, 99);
            mon = bound(c.mon, 1, 12);
            loaded.cent = 7'(cen);
            loaded.year = 7'(yr);
            loaded.mon  = 4'(mon);
            loaded.day  = 5'(bound(c.day, 1, month_length(cen, yr, mon)));
            loaded.hour = 5'(bound(c.hour, 0, 23));
            loaded.min  = 6'(bound(c.min, 0, 59));
            loaded.sec  = 6'(bound(c.sec, 0, 59));
            fired = 1'b0;
            case (c.op)
                OP_TICK: begin
                    if (clock_running) begin
                        clock_now = step_second(clock_now);
                        if (alarm_pending && clock_now.tm >= alarm_at) begin
                            fired = 1'b1;
                            alarm_pending = 1'b0;
                        end
                    end
                end
                OP_LOAD: begin
                    clock_now.tm   = loaded;
                    clock_now.wday = 3'(bound(c.wday, 1, 7));
                    clock_running  = 1'b1;
                end
                OP_ALARM: begin
                    alarm_at      = loaded;
                    alarm_pending = 1'b1;
                end
                OP_DISARM: alarm_pending = 1'b0;
                OP_STOP:   clock_running = 1'b0;
                default: ;
            endcase
            r.stamp   = clock_now;
            r.fired   = fired;
            r.armed   = alarm_pending;
            r.running = clock_running;
            expected_readings.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED) $display("MISMATCH: %s", msg);
        endtask

        task check_field(string name, logic [6:0] got, logic [6:0] want);
            if (got !== want)
                report($sformatf("reading %0d %s: got %0d expected %0d",
                                 readings_seen, name, got, want));
        endtask

        // Compare one accepted reading with the oldest one owed
        task check_reading(t_reading got);
            t_reading want;
            if (expected_readings.size() == 0) begin
                report($sformatf("reading %0d arrived with nothing expected", readings_seen));
                readings_seen++;
                return;
            end
            want = expected_readings.pop_front();
            check_field("century", got.stamp.tm.cent, want.stamp.tm.cent);
            check_field("year",    got.stamp.tm.year, want.stamp.tm.year);
            check_field("month",   7'(got.stamp.tm.mon),  7'(want.stamp.tm.mon));
            check_field("day",     7'(got.stamp.tm.day),  7'(want.stamp.tm.day));
            check_field("hour",    7'(got.stamp.tm.hour), 7'(want.stamp.tm.hour));
            check_field("minute",  7'(got.stamp.tm.min),  7'(want.stamp.tm.min));
            check_field("second",  7'(got.stamp.tm.sec),  7'(want.stamp.tm.sec));
            check_field("weekday", 7'(got.stamp.wday),    7'(want.stamp.wday));
            check_field("fired",   7'(got.fired),         7'(want.fired));
            check_field("armed",   7'(got.armed),         7'(want.armed));
            check_field("running", 7'(got.running),       7'(want.running));
            readings_seen++;
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [2:0] i_operation = '0;
    logic [6:0] i_century = '0;
    logic [6:0] i_year_in_century = '0;
    logic [3:0] i_month = '0;
    logic [4:0] i_day = '0;
    logic [4:0] i_hour = '0;
    logic [5:0] i_minute = '0;
    logic [5:0] i_second = '0;
    logic [2:0] i_weekday = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [6:0] o_now_century;
    logic [6:0] o_now_year;
    logic [3:0] o_now_month;
    logic [4:0] o_now_day;
    logic [4:0] o_now_hour;
    logic [5:0] o_now_minute;
    logic [5:0] o_now_second;
    logic [2:0] o_now_weekday;
    logic       o_alarm_fired;
    logic       o_alarm_armed;
    logic       o_running;

    t_clock_scoreboard sb;
    int  items_sent = 0;
    int  cycle_count = 0;
    int  hold_request = 0;
    int  hold_left = 0;
    int  stall_left = 0;
    bit  rx_quiet = 1'b0;
    bit  tx_quiet = 1'b0;

    calendar_clock_with_alarm_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_operation       (i_operation),
        .i_century         (i_century),
        .i_year_in_century (i_year_in_century),
        .i_month           (i_month),
        .i_day             (i_day),
        .i_hour            (i_hour),
        .i_minute          (i_minute),
        .i_second          (i_second),
        .i_weekday         (i_weekday),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_now_century     (o_now_century),
        .o_now_year        (o_now_year),
        .o_now_month       (o_now_month),
        .o_now_day         (o_now_day),
        .o_now_hour        (o_now_hour),
        .o_now_minute      (o_now_minute),
        .o_now_second      (o_now_second),
        .o_now_weekday     (o_now_weekday),
        .o_alarm_fired     (o_alarm_fired),
        .o_alarm_armed     (o_alarm_armed),
        .o_running         (o_running)
    );

    always #6 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("calendar_clock_with_alarm_core_test: errors");
            $finish;
        end
    end

    // Idle length: mostly short, now and then long
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 1;
        if (r < 88) return $urandom_range(2, 4);
        if (r < 97) return $urandom_range(5, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int next_gap();
        if (tx_quiet || $urandom_range(0, 1) == 0) return 0;
        return idle_span();
    endfunction

    // Result side: random stalls, quiet stretches, and the long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready = 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) rx_quiet = !rx_quiet;
            if (!rx_quiet && $urandom_range(0, 3) == 0) begin
                stall_left = idle_span() - 1;
                i_ready = 1'b0;
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_reading got;
        if (i_rst_n && o_valid && i_ready) begin
            got.stamp.tm.cent = o_now_century;
            got.stamp.tm.year = o_now_year;
            got.stamp.tm.mon  = o_now_month;
            got.stamp.tm.day  = o_now_day;
            got.stamp.tm.hour = o_now_hour;
            got.stamp.tm.min  = o_now_minute;
            got.stamp.tm.sec  = o_now_second;
            got.stamp.wday    = o_now_weekday;
            got.fired         = o_alarm_fired;
            got.armed         = o_alarm_armed;
            got.running       = o_running;
            sb.check_reading(got);
        end
    end

    function automatic t_cmd mk(logic [2:0] op, int cen, int yr, int mon, int day,
                                int hh, int mm, int ss, int wd);
        t_cmd c;
        c.op = op;       c.cen = 7'(cen); c.yr = 7'(yr);  c.mon = 4'(mon); c.day = 5'(day);
        c.hour = 5'(hh); c.min = 6'(mm);  c.sec = 6'(ss); c.wday = 3'(wd);
        return c;
    endfunction

    // All payload bits random; only the operation is fixed
    function automatic t_cmd raw_cmd(logic [2:0] op);
        t_cmd        c;
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        c = bits[$bits(t_cmd)-1:0];
        c.op = op;
        return c;
    endfunction

    // Well-formed load close to a carry boundary, sometimes raw
    function automatic t_cmd near_rollover_load();
        t_cmd c;
        c = raw_cmd(OP_LOAD);
        if ($urandom_range(0, 5) != 0) begin
            c.cen  = 7'($urandom_range(0, 1) ? 99 : $urandom_range(0, 99));
            c.yr   = 7'($urandom_range(0, 2) == 0 ? 99 :
                        ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 99)));
            c.mon  = 4'($urandom_range(0, 2) == 0 ? 12 :
                        ($urandom_range(0, 2) == 0 ? 2 : $urandom_range(1, 12)));
            c.day  = 5'($urandom_range(0, 2) == 0 ? $urandom_range(1, 31)
                                                   : $urandom_range(28, 31));
            c.hour = 5'($urandom_range(0, 1) ? 23 : $urandom_range(0, 23));
            c.min  = 6'($urandom_range(0, 1) ? 59 : $urandom_range(0, 59));
            c.sec  = 6'($urandom_range(50, 59));
            c.wday = 3'($urandom_range(0, 7));
        end
        return c;
    endfunction

    // Alarm a few seconds ahead of the predicted time, sometimes raw
    function automatic t_cmd upcoming_alarm();
        t_cmd   c;
        t_stamp t;
        c = raw_cmd(OP_ALARM);
        if ($urandom_range(0, 4) != 0) begin
            t = sb.clock_now;
            repeat ($urandom_range(0, 12)) t = sb.step_second(t);
            c.cen = t.tm.cent;  c.yr = t.tm.year; c.mon = t.tm.mon; c.day = t.tm.day;
            c.hour = t.tm.hour; c.min = t.tm.min; c.sec = t.tm.sec;
        end
        return c;
    endfunction

    // Offer one beat after a gap; valid stays up until the core takes it
    task automatic send_cmd(input t_cmd c, input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid           = 1'b1;
        i_operation       = c.op;
        i_century         = c.cen;
        i_year_in_century = c.yr;
        i_month           = c.mon;
        i_day             = c.day;
        i_hour            = c.hour;
        i_minute          = c.min;
        i_second          = c.sec;
        i_weekday         = c.wday;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        sb.accept_command(c);
        items_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_cmd(raw_cmd(OP_TICK), next_gap());
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        int  directed_count;
        int  choice;
        bit  hold_done;
        bit  pause_done;
        logic [2:0] misc_op;
        sb = new();
        hold_done = 1'b0;
        pause_done = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Tick while stopped, then the unused operation codes
        send_ticks(1);
        for (int c = OP_STOP + 1; c < NUM_OP_CODES; c++) send_cmd(raw_cmd(3'(c)), next_gap());
        // Last second of century 99 wraps everything
        send_cmd(mk(OP_LOAD, 99, 99, 12, 31, 23, 59, 59, 7), next_gap());
        send_ticks(1);
        // Clamping of every field, high side and low side
        send_cmd(mk(OP_LOAD, 127, 127, 15, 31, 31, 63, 63, 0), next_gap());
        send_cmd(mk(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0), next_gap());
        // February: leap via century, non-leap century year, ordinary leap year
        send_cmd(mk(OP_LOAD, 20, 0, 2, 31, 23, 59, 59, 3), next_gap());
        send_ticks(1);
        send_cmd(mk(OP_LOAD, 21, 0, 2, 28, 23, 59, 59, 3), next_gap());
        send_ticks(1);
        send_cmd(mk(OP_LOAD, 20, 4, 2, 28, 23, 59, 59, 3), next_gap());
        send_ticks(1);
        // Last day of a 30-day month
        send_cmd(mk(OP_LOAD, 20, 25, 4, 30, 23, 59, 59, 3), next_gap());
        send_ticks(1);
        // Alarm two seconds ahead: not checked on load, fires once on reach
        send_cmd(mk(OP_ALARM, 20, 25, 5, 1, 0, 0, 2, 5), next_gap());
        send_ticks(3);
        // Alarm already passed fires on the next tick
        send_cmd(mk(OP_ALARM, 0, 0, 1, 1, 0, 0, 0, 0), next_gap());
        send_ticks(1);
        // Far alarm, stop, tick while stopped, disarm
        send_cmd(mk(OP_ALARM, 99, 99, 12, 31, 23, 59, 59, 7), next_gap());
        send_cmd(raw_cmd(OP_STOP), next_gap());
        send_ticks(1);
        send_cmd(raw_cmd(OP_DISARM), next_gap());
        directed_count = items_sent;
        drain_results();

        // Random part: loads near carries, alarms just ahead, tick bursts, odd commands
        while (items_sent < directed_count + RANDOM_ITEMS) begin
            if (!hold_done && items_sent >= directed_count + 500) begin
                hold_done = 1'b1;
                hold_request = LONG_HOLD;
                repeat (40) send_cmd(raw_cmd(OP_TICK), 0);
            end
            if (!pause_done && items_sent >= directed_count + 1100) begin
                pause_done = 1'b1;
                drain_results();
            end
            if ($urandom_range(0, 9) == 0) tx_quiet = !tx_quiet;
            choice = $urandom_range(0, 99);
            if (choice < 30) begin
                send_cmd(near_rollover_load(), next_gap());
                send_ticks($urandom_range(1, 20));
            end else if (choice < 50) begin
                send_cmd(upcoming_alarm(), next_gap());
                send_ticks($urandom_range(1, 15));
            end else if (choice < 85) begin
                send_ticks($urandom_range(1, 30));
            end else begin
                case ($urandom_range(0, 3))
                    0:       misc_op = OP_DISARM;
                    1:       misc_op = OP_STOP;
                    2:       misc_op = 3'($urandom_range(OP_STOP + 1, NUM_OP_CODES - 1));
                    default: misc_op = 3'($urandom_range(0, NUM_OP_CODES - 1));
                endcase
                send_cmd(raw_cmd(misc_op), next_gap());
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("calendar_clock_with_alarm_core_test: clean");
        end else begin
            $display("calendar_clock_with_alarm_core_test: errors");
        end
        $finish;
    end

endmodule
